// ===== hw/rtl/dtt_pkg.sv =====
// Shared types and constants for the definition text tokenizer.
package dtt_pkg;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_COMMENT = 5'b00010,
        MODE_TAG     = 5'b00100,
        MODE_NUMBER  = 5'b01000,
        MODE_STRING  = 5'b10000
    } t_lex_mode;

    localparam logic [2:0] KIND_TAG     = 3'd0;
    localparam logic [2:0] KIND_NUMBER  = 3'd1;
    localparam logic [2:0] KIND_STRBYTE = 3'd2;
    localparam logic [2:0] KIND_STREND  = 3'd3;
    localparam logic [2:0] KIND_OPEN    = 3'd4;
    localparam logic [2:0] KIND_CLOSE   = 3'd5;
    localparam logic [2:0] KIND_ERROR   = 3'd6;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_LBRACE = 8'd123;
    localparam logic [7:0] CH_RBRACE = 8'd125;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
        logic        last;
    } t_token;

    // Results of one byte: count of valid tokens (0..2), slot 0 first.
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    function automatic logic is_letter(input logic [7:0] c);
        return (c > 8'd64 && c < 8'd91) || (c > 8'd96 && c < 8'd123);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c > 8'd47 && c < 8'd58;
    endfunction

endpackage

// ===== hw/rtl/dtt_lexer.sv =====
// Lexer state and per-byte token logic for the definition text tokenizer.
module dtt_lexer #(
    parameter int MAX_DEPTH = 3
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_byte,
    output dtt_pkg::t_push o_push
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

    dtt_pkg::t_lex_mode r_mode, n_mode;
    logic [31:0]        r_hash, n_hash;
    logic [63:0]        r_acc,  n_acc;
    logic [DEPTH_W-1:0] r_depth, n_depth;

    logic [31:0]   hash_src;
    logic [31:0]   hash_next;
    logic [63:0]   digit_val;
    logic [63:0]   acc_next;
    logic          do_class;
    logic          allow_tag;
    logic          allow_num;
    logic          ct_valid;
    dtt_pkg::t_token ct;
    dtt_pkg::t_push  push;

    // One FNV step shared by tag continuation and tag start; only the low 32 bits matter.
    assign hash_src  = (r_mode == dtt_pkg::MODE_TAG) ? r_hash : dtt_pkg::FNV_BASIS;
    assign hash_next = (hash_src ^ {24'd0, i_byte}) * dtt_pkg::FNV_PRIME;
    assign digit_val = {60'd0, i_byte[3:0]};
    assign acc_next  = (r_acc << 3) + (r_acc << 1) + digit_val;

    always_comb begin
        n_mode    = r_mode;
        n_hash    = r_hash;
        n_acc     = r_acc;
        n_depth   = r_depth;
        push      = '0;
        do_class  = 1'b0;
        allow_tag = 1'b0;
        allow_num = 1'b0;
        ct_valid  = 1'b0;
        ct        = '0;
        if (i_valid) begin
            unique case (r_mode)
                dtt_pkg::MODE_COMMENT: begin
                    if (i_byte == dtt_pkg::CH_LF) n_mode = dtt_pkg::MODE_IDLE;
                end
                dtt_pkg::MODE_TAG: begin
                    if (dtt_pkg::is_letter(i_byte) || dtt_pkg::is_digit(i_byte)) begin
                        n_hash = hash_next;
                    end else begin
                        push.tok0.kind  = dtt_pkg::KIND_TAG;
                        push.tok0.value = {32'd0, r_hash};
                        push.cnt        = 2'd1;
                        n_hash          = dtt_pkg::FNV_BASIS;
                        do_class        = 1'b1;
                        allow_num       = 1'b1;
                    end
                end
                dtt_pkg::MODE_NUMBER: begin
                    if (dtt_pkg::is_digit(i_byte)) begin
                        n_acc = acc_next;
                    end else begin
                        push.tok0.kind  = dtt_pkg::KIND_NUMBER;
                        push.tok0.value = r_acc;
                        push.cnt        = 2'd1;
                        n_acc           = '0;
                        do_class        = 1'b1;
                    end
                end
                dtt_pkg::MODE_STRING: begin
                    push.cnt = 2'd1;
                    if (i_byte == dtt_pkg::CH_QUOTE) begin
                        push.tok0.kind = dtt_pkg::KIND_STREND;
                        n_mode         = dtt_pkg::MODE_IDLE;
                    end else begin
                        push.tok0.kind  = dtt_pkg::KIND_STRBYTE;
                        push.tok0.value = {56'd0, i_byte};
                    end
                end
                dtt_pkg::MODE_IDLE: begin
                    do_class  = 1'b1;
                    allow_tag = 1'b1;
                    allow_num = 1'b1;
                end
                default: n_mode = dtt_pkg::MODE_IDLE;
            endcase

            // Terminator / fresh byte classification; later categories only after a token.
            if (do_class) begin
                n_mode = dtt_pkg::MODE_IDLE;
                if (allow_tag && i_byte == dtt_pkg::CH_HASH) begin
                    n_mode = dtt_pkg::MODE_COMMENT;
                end else if (allow_tag && dtt_pkg::is_letter(i_byte)) begin
                    n_mode = dtt_pkg::MODE_TAG;
                    n_hash = hash_next;
                end else if (allow_num && dtt_pkg::is_digit(i_byte)) begin
                    n_mode = dtt_pkg::MODE_NUMBER;
                    n_acc  = digit_val;
                end else if (i_byte == dtt_pkg::CH_QUOTE) begin
                    n_mode = dtt_pkg::MODE_STRING;
                end else if (i_byte == dtt_pkg::CH_LBRACE) begin
                    ct_valid = 1'b1;
                    if (r_depth >= DEPTH_W'(MAX_DEPTH)) begin
                        ct.kind = dtt_pkg::KIND_ERROR;
                    end else begin
                        n_depth  = r_depth + 1'b1;
                        ct.kind  = dtt_pkg::KIND_OPEN;
                        ct.value = {{(64-DEPTH_W){1'b0}}, n_depth};
                    end
                end else if (i_byte == dtt_pkg::CH_RBRACE) begin
                    ct_valid = 1'b1;
                    if (r_depth == '0) begin
                        ct.kind = dtt_pkg::KIND_ERROR;
                    end else begin
                        n_depth  = r_depth - 1'b1;
                        ct.kind  = dtt_pkg::KIND_CLOSE;
                        ct.value = {{(64-DEPTH_W){1'b0}}, n_depth};
                    end
                end
                if (ct_valid) begin
                    if (push.cnt == 2'd0) push.tok0 = ct;
                    else                  push.tok1 = ct;
                    push.cnt = push.cnt + 2'd1;
                end
            end
            push.tok0.last = (push.cnt == 2'd1);
            push.tok1.last = 1'b1;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= dtt_pkg::MODE_IDLE;
            r_hash  <= dtt_pkg::FNV_BASIS;
            r_acc   <= '0;
            r_depth <= '0;
        end else begin
            r_mode  <= n_mode;
            r_hash  <= n_hash;
            r_acc   <= n_acc;
            r_depth <= n_depth;
        end
    end

endmodule

// ===== hw/rtl/definition_text_tokenizer_core.sv =====
// Top level of the definition text tokenizer: input register, lexer and output queue.
// Path: an accepted byte is held in the input register, lexed combinationally, and its
// results are written into the token queue, whose head drives the output port.
// Throughput: one byte per cycle while s_axis_tready is high; a byte with two results
// takes two output beats, so the output port and the eight-entry token queue set the
// sustained rate. s_axis_tready drops once the queue holds more than four tokens.
// Reset (synchronous, active low): lexer back to idle at depth zero, queue emptied.
module definition_text_tokenizer_core #(
    parameter int MAX_DEPTH = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] token_value
    output logic [2:0]  m_axis_tuser,   // [2:0] token_kind
    output logic        m_axis_tlast    // last_of_run
);

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    // Room for the byte in the input register and the one being taken, two tokens each.
    localparam int READY_MAX  = FIFO_DEPTH - 4;

    // Input register stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       in_beat;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in_valid <= 1'b0;
        else          r_in_valid <= in_beat;
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) r_in_byte <= s_axis_tdata;
    end

    // Lexer: state registers and the token logic for the registered byte
    dtt_pkg::t_push push;

    dtt_lexer #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_lexer (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_in_valid),
        .i_byte (r_in_byte),
        .o_push (push)
    );

    // Token queue: up to two writes and one read per cycle
    dtt_pkg::t_token r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             out_beat;
    logic [PTR_W-1:0] wr_ptr_p1;

    assign out_beat  = m_axis_tvalid && m_axis_tready;
    assign wr_ptr_p1 = r_wr_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (push.cnt != 2'd0) r_mem[r_wr_ptr]  <= push.tok0;
        if (push.cnt == 2'd2) r_mem[wr_ptr_p1] <= push.tok1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(push.cnt);
            if (out_beat) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count  <= r_count + CNT_W'(push.cnt) - CNT_W'(out_beat);
        end
    end

    assign s_axis_tready = (r_count <= CNT_W'(READY_MAX));
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = r_mem[r_rd_ptr].value;
    assign m_axis_tuser  = r_mem[r_rd_ptr].kind;
    assign m_axis_tlast  = r_mem[r_rd_ptr].last;

endmodule

// ===== hw/rtl/dtt_checker.sv =====
// Port-level checks for the definition text tokenizer, bound to the top level.
module dtt_checker #(
    parameter int MAX_DEPTH = 3
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // Output beat held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // Queue empty and input open after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("tokens present after reset");

    // Tag hashes are 32 bits; string end and error carry zero
    a_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == dtt_pkg::KIND_TAG) |-> m_axis_tdata[63:32] == 32'd0)
        else $error("tag hash wider than 32 bits");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == dtt_pkg::KIND_STREND
            || m_axis_tuser == dtt_pkg::KIND_ERROR) |-> m_axis_tdata == 64'd0)
        else $error("non-zero value on string end or error");

    // Scope depth within limit; an open or close token always ends its run
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == dtt_pkg::KIND_OPEN
            || m_axis_tuser == dtt_pkg::KIND_CLOSE)
            |-> m_axis_tlast && m_axis_tdata <= 64'(MAX_DEPTH))
        else $error("scope token out of range or not last");

endmodule

bind definition_text_tokenizer_core dtt_checker #(.MAX_DEPTH(MAX_DEPTH)) u_dtt_checker (.*);

// ===== tb/tb_definition_text_tokenizer_core.sv =====
// Self-checking testbench for the tokenizer core: stream driver, predictor, monitor.
module tb_definition_text_tokenizer_core;

    localparam int MAX_DEPTH   = 3;
    localparam int TEXT_ITEMS  = 1150;      // bytes in the random part
    localparam int CYCLE_LIMIT = 600000;    // several times the slowest legal run
    localparam int DRAIN_CYCLES = 20;       // ample margin for the last results to drain

    // Clock, reset and the DUT's stream ports; every input known from time zero.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;       // [7:0] text_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;              // [63:0] token_value
    logic [2:0]  m_axis_tuser;              // [2:0] token_kind
    logic        m_axis_tlast;              // last_of_run

    definition_text_tokenizer_core #(
        .MAX_DEPTH(MAX_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial forever #1 i_clk = ~i_clk;

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Text still to be sent, and tokens predicted but not yet seen on the output.
    logic [7:0]      text_q[$];
    dtt_pkg::t_token token_expect[$];
    dtt_pkg::t_token byte_tokens[$];     // tokens raised by the byte being lexed

    int cycle_cnt = 0;
    int bytes_in = 0;
    int tokens_out = 0;
    int errors = 0;
    int kind_seen[7];

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    // ------------------------------------------------------------------
    // Lexer model: own copy of the mode, running hash, accumulator, depth
    // ------------------------------------------------------------------
    dtt_pkg::t_lex_mode lex_state = dtt_pkg::MODE_IDLE;
    logic [31:0]        tag_hash  = dtt_pkg::FNV_BASIS;
    logic [63:0]        num_acc   = 64'd0;
    int                 scope_lvl = 0;

    function automatic logic alpha_char(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic logic numeral_char(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic void emit_token(input logic [2:0] kind, input logic [63:0] value);
        byte_tokens.push_back(dtt_pkg::t_token'{kind, value, 1'b0});
    endfunction

    // Start a new token from idle. stage 0 accepts every category; a byte that
    // ended a tag comes in at stage 1 (digit onward), one that ended a number
    // at stage 2 (quote and braces only). Anything left over is dropped.
    function automatic void lex_start(input logic [7:0] c, input int stage);
        lex_state = dtt_pkg::MODE_IDLE;
        if (stage == 0 && c == dtt_pkg::CH_HASH) begin
            lex_state = dtt_pkg::MODE_COMMENT;
        end else if (stage == 0 && alpha_char(c)) begin
            lex_state = dtt_pkg::MODE_TAG;
            tag_hash  = (dtt_pkg::FNV_BASIS ^ {24'd0, c}) * dtt_pkg::FNV_PRIME;
        end else if (stage <= 1 && numeral_char(c)) begin
            lex_state = dtt_pkg::MODE_NUMBER;
            num_acc   = {56'd0, c - 8'd48};
        end else if (c == dtt_pkg::CH_QUOTE) begin
            lex_state = dtt_pkg::MODE_STRING;
        end else if (c == dtt_pkg::CH_LBRACE) begin
            // too deep: error, depth held
            if (scope_lvl >= MAX_DEPTH) begin
                emit_token(dtt_pkg::KIND_ERROR, 64'd0);
            end else begin
                scope_lvl++;
                emit_token(dtt_pkg::KIND_OPEN, 64'(scope_lvl));
            end
        end else if (c == dtt_pkg::CH_RBRACE) begin
            // close at root: error, depth held
            if (scope_lvl == 0) begin
                emit_token(dtt_pkg::KIND_ERROR, 64'd0);
            end else begin
                scope_lvl--;
                emit_token(dtt_pkg::KIND_CLOSE, 64'(scope_lvl));
            end
        end
    endfunction

    // One accepted byte: advance the model and queue the tokens it raises.
    function automatic void lex_byte(input logic [7:0] c);
        byte_tokens.delete();
        case (lex_state)
            dtt_pkg::MODE_COMMENT: begin
                if (c == dtt_pkg::CH_LF) lex_state = dtt_pkg::MODE_IDLE;
            end
            dtt_pkg::MODE_TAG: begin
                if (alpha_char(c) || numeral_char(c)) begin
                    tag_hash = (tag_hash ^ {24'd0, c}) * dtt_pkg::FNV_PRIME;
                end else begin
                    emit_token(dtt_pkg::KIND_TAG, {32'd0, tag_hash});
                    tag_hash = dtt_pkg::FNV_BASIS;
                    lex_start(c, 1);
                end
            end
            dtt_pkg::MODE_NUMBER: begin
                if (numeral_char(c)) begin
                    num_acc = num_acc * 64'd10 + {56'd0, c - 8'd48};
                end else begin
                    emit_token(dtt_pkg::KIND_NUMBER, num_acc);
                    num_acc = 64'd0;
                    lex_start(c, 2);
                end
            end
            dtt_pkg::MODE_STRING: begin
                // the closing quote belongs to the string and is not rechecked
                if (c == dtt_pkg::CH_QUOTE) begin
                    emit_token(dtt_pkg::KIND_STREND, 64'd0);
                    lex_state = dtt_pkg::MODE_IDLE;
                end else begin
                    emit_token(dtt_pkg::KIND_STRBYTE, {56'd0, c});
                end
            end
            default: lex_start(c, 0);
        endcase
        if (byte_tokens.size() != 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
        foreach (byte_tokens[j]) token_expect.push_back(byte_tokens[j]);
    endfunction

    // ------------------------------------------------------------------
    // Idle lengths: drawn at random per beat, with stretches of back-to-back
    // ------------------------------------------------------------------
    bit src_burst = 1'b0;
    bit snk_burst = 1'b0;

    function automatic int hold_cycles(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 19));
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents one text byte per beat from text_q
    // ------------------------------------------------------------------
    int src_wait = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_wait      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                lex_byte(s_axis_tdata);
                bytes_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_wait != 0) begin
                    src_wait      <= src_wait - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (text_q.size() != 0) begin
                    s_axis_tdata  <= text_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 49) == 0) src_burst = !src_burst;
                    src_wait      <= hold_cycles(src_burst);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, each token beat checked in order
    // ------------------------------------------------------------------
    int              snk_wait = 0;
    int              snk_hold;
    dtt_pkg::t_token tok_got;
    dtt_pkg::t_token tok_want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            snk_wait      <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            tok_got = '{m_axis_tuser, m_axis_tdata, m_axis_tlast};
            tokens_out++;
            if (tok_got.kind < 3'd7) kind_seen[tok_got.kind]++;
            if (token_expect.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected token: kind %0d value 0x%016h last %0b",
                             tok_got.kind, tok_got.value, tok_got.last);
            end else begin
                tok_want = token_expect.pop_front();
                if (tok_got !== tok_want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"token %0d mismatch: want kind %0d value 0x%016h last %0b,",
                                  " got kind %0d value 0x%016h last %0b"},
                                 tokens_out, tok_want.kind, tok_want.value, tok_want.last,
                                 tok_got.kind, tok_got.value, tok_got.last);
                end
            end
            if ($urandom_range(0, 49) == 0) snk_burst = !snk_burst;
            snk_hold = hold_cycles(snk_burst);
            if (snk_hold == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                snk_wait      <= snk_hold - 1;
            end
        end else if (snk_wait != 0) begin
            snk_wait <= snk_wait - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'(65 + $urandom_range(0, 25))
                                    : 8'(97 + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(48 + $urandom_range(0, 9));
    endfunction

    // Byte that closes a tag or number: covers dropped and rechecked cases.
    function automatic logic [7:0] rand_term();
        case ($urandom_range(0, 8))
            0:       return 8'd32;
            1:       return dtt_pkg::CH_LF;
            2:       return dtt_pkg::CH_LBRACE;
            3:       return dtt_pkg::CH_RBRACE;
            4:       return dtt_pkg::CH_QUOTE;
            5:       return dtt_pkg::CH_HASH;
            6:       return rand_digit();
            7:       return rand_letter();
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Text generation and end of run
    // ------------------------------------------------------------------
    initial begin
        int sig;
        int pick;
        int len;
        logic [7:0] b;

        sig = 0;
        // Directed: overflow past MAX_DEPTH, tag ending in a quote, extreme
        // string bytes, number closed by a brace, dropped terminators, a
        // comment, then closes down past the root.
        push_text("{{{{Zz09\"");
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        push_text("#\"19}a#5q#x");
        text_q.push_back(dtt_pkg::CH_LF);
        push_text("}}}");

        // Random: mostly well-formed tokens with random content, some noise.
        while (sig < TEXT_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                len = $urandom_range(1, 8);
                text_q.push_back(rand_letter());
                for (int i = 1; i < len; i++)
                    text_q.push_back($urandom_range(0, 2) ? rand_letter() : rand_digit());
                text_q.push_back(rand_term());
                sig += len + 1;
            end else if (pick < 45) begin
                if ($urandom_range(0, 19) == 0) begin
                    // either side of the 2^64 wrap
                    push_text($urandom_range(0, 1) ? "18446744073709551615"
                                                   : "18446744073709551616");
                    len = 20;
                end else begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 24)
                                                      : $urandom_range(1, 6);
                    for (int i = 0; i < len; i++) text_q.push_back(rand_digit());
                end
                text_q.push_back(rand_term());
                sig += len + 1;
            end else if (pick < 60) begin
                len = $urandom_range(0, 10);
                text_q.push_back(dtt_pkg::CH_QUOTE);
                for (int i = 0; i < len; i++) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == dtt_pkg::CH_QUOTE) b = 8'h22 ^ 8'h80;
                    text_q.push_back(b);
                end
                text_q.push_back(dtt_pkg::CH_QUOTE);
                sig += len + 2;
            end else if (pick < 75) begin
                text_q.push_back(($urandom_range(0, 99) < 55) ? dtt_pkg::CH_LBRACE
                                                              : dtt_pkg::CH_RBRACE);
                sig++;
            end else if (pick < 85) begin
                // comment body with no newline inside
                len = $urandom_range(0, 8);
                text_q.push_back(dtt_pkg::CH_HASH);
                for (int i = 0; i < len; i++) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == dtt_pkg::CH_LF) b = 8'h8A;
                    text_q.push_back(b);
                end
                text_q.push_back(dtt_pkg::CH_LF);
                sig += len + 2;
            end else begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) text_q.push_back(8'($urandom_range(0, 255)));
                sig += len;
            end
        end
        // unfinished tag at the tail: stays pending, nothing flushed
        push_text("tail9");

        // All text accepted, then every predicted token seen, then a drain.
        while (text_q.size() != 0 || s_axis_tvalid || !i_rst_n) @(posedge i_clk);
        while (token_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d text bytes and %0d token beats under random stalls on both sides.",
                 bytes_in, tokens_out);
        $display({"Tokens: %0d tag, %0d number, %0d string byte, %0d string end,",
                  " %0d open, %0d close, %0d error."},
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
                 kind_seen[4], kind_seen[5], kind_seen[6]);
        if (errors == 0 && token_expect.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog on the cycle counter.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("Timed out after %0d cycles, %0d tokens outstanding", cycle_cnt,
                 token_expect.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
